@@ sv/itsm_pkg.sv @@
// Shared types and constants of the tile stitch merge block.
// Used by itsm_cfg, itsm_ctrl, itsm_dp and image_tile_stitch_merge; no dependencies.
package itsm_pkg;

    // View geometry
    localparam int PLANE_COUNT = 3;
    localparam int VIEW_ROWS   = 1024;
    localparam int VIEW_COLS   = 1024;

    localparam int VROW_DEPTH  = PLANE_COUNT * VIEW_ROWS;
    localparam int PIXEL_DEPTH = VROW_DEPTH * VIEW_COLS;
    localparam int VR_W        = $clog2(VIEW_ROWS);
    localparam int VC_W        = $clog2(VIEW_COLS);
    localparam int VROW_IDX_W  = (VROW_DEPTH > 1) ? $clog2(VROW_DEPTH) : 1;
    localparam int PIX_ADDR_W  = $clog2(PIXEL_DEPTH);

    // Field widths
    localparam int OP_W     = 2;
    localparam int COORD_W  = 10;
    localparam int SCORE_W  = 16;
    localparam int METRIC_W = 21;
    localparam int SQ_W     = 2 * COORD_W;
    localparam int TILE_W   = 11;
    localparam int OFS_W    = 11;
    localparam int PLANE_W  = 2;
    localparam int POS_W    = 14;   // signed view position incl. offset

    // Operation codes
    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_ROWS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_COLS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_OFFSET   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_OFFSET   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_SELECT = 3'd6;

    localparam logic [TILE_W-1:0] TILE_SIZE_RESET = 11'd512;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [SCORE_W-1:0] score;
    } t_in_item;

    typedef struct packed {
        logic               written;
        logic [SCORE_W-1:0] pixel_value;
        logic               pixel_set;
    } t_out_item;

    typedef struct packed {
        logic                    score_mode;
        logic [SCORE_W-1:0]      threshold;
        logic [TILE_W-1:0]       tile_rows;
        logic [TILE_W-1:0]       tile_cols;
        logic signed [OFS_W-1:0] row_offset;
        logic signed [OFS_W-1:0] col_offset;
        logic [PLANE_W-1:0]      plane_select;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic ready;     // idle, input item may be taken
        logic calc_en;   // register view position, checks and squares
        logic addr_en;   // register new metric, memories addressed
        logic sweep;     // clear one row of set flags
        logic commit;    // write pixel if taken, load result
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_clear;
        logic sweep_last;
        logic out_free;
    } t_sts;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CALC,
        S_ADDR,
        S_CLEAR,
        S_LOOK
    } t_state;

endpackage

@@ sv/itsm_cfg.sv @@
// Configuration register file of the tile stitch merge block.
// Depends on itsm_pkg.
module itsm_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [itsm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [itsm_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output itsm_pkg::t_cfg                 o_cfg
);

    itsm_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register writes; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.score_mode   <= 1'b0;
            r_cfg.threshold    <= '0;
            r_cfg.tile_rows    <= itsm_pkg::TILE_SIZE_RESET;
            r_cfg.tile_cols    <= itsm_pkg::TILE_SIZE_RESET;
            r_cfg.row_offset   <= '0;
            r_cfg.col_offset   <= '0;
            r_cfg.plane_select <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                itsm_pkg::CFG_SCORE_MODE:   r_cfg.score_mode <= i_cfg_data[0];
                itsm_pkg::CFG_THRESHOLD:    r_cfg.threshold  <= i_cfg_data;
                itsm_pkg::CFG_TILE_ROWS: begin
                    r_cfg.tile_rows <= i_cfg_data[itsm_pkg::TILE_W-1:0];
                end
                itsm_pkg::CFG_TILE_COLS: begin
                    r_cfg.tile_cols <= i_cfg_data[itsm_pkg::TILE_W-1:0];
                end
                itsm_pkg::CFG_ROW_OFFSET: begin
                    r_cfg.row_offset <= $signed(i_cfg_data[itsm_pkg::OFS_W-1:0]);
                end
                itsm_pkg::CFG_COL_OFFSET: begin
                    r_cfg.col_offset <= $signed(i_cfg_data[itsm_pkg::OFS_W-1:0]);
                end
                itsm_pkg::CFG_PLANE_SELECT: begin
                    r_cfg.plane_select <= i_cfg_data[itsm_pkg::PLANE_W-1:0];
                end
                default: ;
            endcase
        end
    end

endmodule

@@ sv/itsm_ctrl.sv @@
// Sequencing state machine of the tile stitch merge block.
// Depends on itsm_pkg; drives the datapath through t_cmd, reads t_sts.
module itsm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  itsm_pkg::t_sts i_sts,
    output itsm_pkg::t_cmd o_cmd
);

    itsm_pkg::t_state r_state;
    itsm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= itsm_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            itsm_pkg::S_INIT: begin
                if (i_sts.sweep_last) n_state = itsm_pkg::S_IDLE;
            end
            itsm_pkg::S_IDLE: begin
                if (i_valid) n_state = itsm_pkg::S_CALC;
            end
            itsm_pkg::S_CALC: begin
                n_state = i_sts.is_clear ? itsm_pkg::S_CLEAR : itsm_pkg::S_ADDR;
            end
            itsm_pkg::S_ADDR: n_state = itsm_pkg::S_LOOK;
            itsm_pkg::S_CLEAR: begin
                if (i_sts.sweep_last) n_state = itsm_pkg::S_LOOK;
            end
            itsm_pkg::S_LOOK: begin
                if (i_sts.out_free) n_state = itsm_pkg::S_IDLE;
            end
            default: n_state = itsm_pkg::S_INIT;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            itsm_pkg::S_INIT:  o_cmd.sweep   = 1'b1;
            itsm_pkg::S_IDLE:  o_cmd.ready   = 1'b1;
            itsm_pkg::S_CALC:  o_cmd.calc_en = 1'b1;
            itsm_pkg::S_ADDR:  o_cmd.addr_en = 1'b1;
            itsm_pkg::S_CLEAR: o_cmd.sweep   = 1'b1;
            itsm_pkg::S_LOOK:  o_cmd.commit  = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

@@ sv/itsm_dp.sv @@
// Datapath of the tile stitch merge block: position and metric arithmetic,
// pixel and set-flag memories, result register. Depends on itsm_pkg.
module itsm_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  itsm_pkg::t_cmd      i_cmd,
    output itsm_pkg::t_sts      o_sts,
    input  itsm_pkg::t_cfg      i_cfg,
    input  logic                i_valid,
    input  itsm_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output itsm_pkg::t_out_item o_item
);

    // Memories: pixel value and metric per pixel, set flags one view row per word
    logic [itsm_pkg::SCORE_W-1:0]   mem_value  [itsm_pkg::PIXEL_DEPTH];
    logic [itsm_pkg::METRIC_W-1:0]  mem_metric [itsm_pkg::PIXEL_DEPTH];
    logic [itsm_pkg::VIEW_COLS-1:0] mem_vflag  [itsm_pkg::VROW_DEPTH];

    itsm_pkg::t_in_item r_item;

    logic                             r_ok_add;
    logic                             r_ok_read;
    logic [itsm_pkg::VROW_IDX_W-1:0]  r_vrow_idx;
    logic [itsm_pkg::VC_W-1:0]        r_vc;
    logic [itsm_pkg::SQ_W-1:0]        r_sq_r;
    logic [itsm_pkg::SQ_W-1:0]        r_sq_c;
    logic [itsm_pkg::METRIC_W-1:0]    r_new_metric;

    logic [itsm_pkg::SCORE_W-1:0]     r_rd_value;
    logic [itsm_pkg::METRIC_W-1:0]    r_rd_metric;
    logic [itsm_pkg::VIEW_COLS-1:0]   r_rd_vword;

    logic [itsm_pkg::VROW_IDX_W-1:0]  r_clr_cnt;

    logic                             r_out_valid;
    itsm_pkg::t_out_item              r_out;

    logic                             c_is_add;
    logic                             c_is_read;
    logic signed [itsm_pkg::POS_W-1:0] c_vr;
    logic signed [itsm_pkg::POS_W-1:0] c_vc;
    logic                             c_in_view;
    logic                             c_plane_ok;
    logic [itsm_pkg::VROW_IDX_W-1:0]  c_vrow_idx;
    logic [itsm_pkg::COORD_W-1:0]     c_dr;
    logic [itsm_pkg::COORD_W-1:0]     c_dc;
    logic [itsm_pkg::COORD_W-1:0]     c_half_r;
    logic [itsm_pkg::COORD_W-1:0]     c_half_c;
    logic [itsm_pkg::PIX_ADDR_W-1:0]  c_pix_addr;
    logic                             c_vbit;
    logic                             c_better;
    logic                             c_take;
    logic                             c_out_free;
    itsm_pkg::t_out_item              c_result;

    // Accept register
    always_ff @(posedge i_clk) begin
        if (i_cmd.ready && i_valid) r_item <= i_item;
    end

    // Position, range checks and distance squares
    always_comb begin
        c_is_add  = (r_item.operation == itsm_pkg::OP_ADD);
        c_is_read = (r_item.operation == itsm_pkg::OP_READ);
        c_vr = $signed({{(itsm_pkg::POS_W-itsm_pkg::COORD_W){1'b0}}, r_item.row});
        c_vc = $signed({{(itsm_pkg::POS_W-itsm_pkg::COORD_W){1'b0}}, r_item.col});
        if (c_is_add) begin
            c_vr = c_vr + $signed({{(itsm_pkg::POS_W-itsm_pkg::OFS_W)
                                    {i_cfg.row_offset[itsm_pkg::OFS_W-1]}}, i_cfg.row_offset});
            c_vc = c_vc + $signed({{(itsm_pkg::POS_W-itsm_pkg::OFS_W)
                                    {i_cfg.col_offset[itsm_pkg::OFS_W-1]}}, i_cfg.col_offset});
        end
        c_in_view = !c_vr[itsm_pkg::POS_W-1] && !c_vc[itsm_pkg::POS_W-1]
                    && (c_vr < itsm_pkg::POS_W'(itsm_pkg::VIEW_ROWS))
                    && (c_vc < itsm_pkg::POS_W'(itsm_pkg::VIEW_COLS));
        c_plane_ok = (32'(i_cfg.plane_select) < itsm_pkg::PLANE_COUNT);
        c_vrow_idx = itsm_pkg::VROW_IDX_W'(32'(i_cfg.plane_select) * itsm_pkg::VIEW_ROWS
                                           + 32'(c_vr[itsm_pkg::VR_W-1:0]));
        c_half_r = i_cfg.tile_rows[itsm_pkg::TILE_W-1:1];
        c_half_c = i_cfg.tile_cols[itsm_pkg::TILE_W-1:1];
        c_dr = (r_item.row >= c_half_r) ? (r_item.row - c_half_r) : (c_half_r - r_item.row);
        c_dc = (r_item.col >= c_half_c) ? (r_item.col - c_half_c) : (c_half_c - r_item.col);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_en) begin
            r_ok_add   <= c_is_add && c_plane_ok && c_in_view
                          && (r_item.score >= i_cfg.threshold);
            r_ok_read  <= c_is_read && c_plane_ok && c_in_view;
            r_vrow_idx <= c_vrow_idx;
            r_vc       <= c_vc[itsm_pkg::VC_W-1:0];
            r_sq_r     <= c_dr * c_dr;
            r_sq_c     <= c_dc * c_dc;
        end
    end

    // New metric: score in confidence mode, squared distance in centre mode
    always_ff @(posedge i_clk) begin
        if (i_cmd.addr_en) begin
            if (i_cfg.score_mode) begin
                r_new_metric <= itsm_pkg::METRIC_W'(r_item.score);
            end else begin
                r_new_metric <= itsm_pkg::METRIC_W'(r_sq_r) + itsm_pkg::METRIC_W'(r_sq_c);
            end
        end
    end

    assign c_pix_addr = itsm_pkg::PIX_ADDR_W'(r_vrow_idx) * itsm_pkg::PIX_ADDR_W'(itsm_pkg::VIEW_COLS)
                        + itsm_pkg::PIX_ADDR_W'(r_vc);

    // Merge decision
    always_comb begin
        c_vbit   = r_rd_vword[r_vc];
        c_better = i_cfg.score_mode ? (r_new_metric > r_rd_metric)
                                    : (r_new_metric < r_rd_metric);
        c_take   = r_ok_add && (!c_vbit || c_better);
        c_result.written     = c_take;
        c_result.pixel_set   = r_ok_read && c_vbit;
        c_result.pixel_value = (r_ok_read && c_vbit) ? r_rd_value : '0;
    end

    // Pixel memories: read every cycle, written on a taken add
    always_ff @(posedge i_clk) begin
        r_rd_value  <= mem_value[c_pix_addr];
        r_rd_metric <= mem_metric[c_pix_addr];
        if (i_cmd.commit && c_take) begin
            mem_value[c_pix_addr]  <= r_item.score;
            mem_metric[c_pix_addr] <= r_new_metric;
        end
    end

    // Set-flag memory: one write port shared by the clear sweep and the add update
    always_ff @(posedge i_clk) begin
        r_rd_vword <= mem_vflag[r_vrow_idx];
        if (i_cmd.sweep) begin
            mem_vflag[r_clr_cnt] <= '0;
        end else if (i_cmd.commit && c_take) begin
            mem_vflag[r_vrow_idx] <= r_rd_vword
                                     | (itsm_pkg::VIEW_COLS'(1) << r_vc);
        end
    end

    // Sweep counter, returns to zero after the last row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.sweep) begin
            if (o_sts.sweep_last) r_clr_cnt <= '0;
            else                  r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    // Result register
    assign c_out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) r_out <= c_result;
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    assign o_sts.is_clear   = (r_item.operation == itsm_pkg::OP_CLEAR);
    assign o_sts.sweep_last = (r_clr_cnt == itsm_pkg::VROW_IDX_W'(itsm_pkg::VROW_DEPTH - 1));
    assign o_sts.out_free   = c_out_free;

endmodule

@@ sv/image_tile_stitch_merge.sv @@
// Top level of the tile stitch merge block: config registers, controller, datapath.
// Depends on itsm_pkg, itsm_cfg, itsm_ctrl and itsm_dp.
//
// Pastes scored tile pixels into per-plane whole-view images. Add and read
// items pass three steps after acceptance (position/checks, memory address,
// read-compare-write); the last step waits until the result register is
// free, and no new item is taken until the last one is through, since the
// read-modify-write of the pixel and set-flag memories must finish first. A
// clear item is accepted and decoded, walks the set-flag memory one view row
// per cycle over PLANE_COUNT * VIEW_ROWS = 3072 rows, and then gives its
// result. After reset the same clearing pass runs before the first item is
// taken; configuration writes are taken at all times. The result register
// lets the next item be accepted while a result still waits on the output.
module image_tile_stitch_merge (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  itsm_pkg::t_in_item             i_item,
    output logic                           o_valid,
    input  logic                           i_stall,
    output itsm_pkg::t_out_item            o_item,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [itsm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [itsm_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    itsm_pkg::t_cfg cfg;
    itsm_pkg::t_cmd cmd;
    itsm_pkg::t_sts sts;

    assign o_stall = !cmd.ready;

    itsm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    itsm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    itsm_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_cfg   (cfg),
        .i_valid (i_valid),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

endmodule
